FILE: hw/rtl/gqa_attention_dv_accumulate_core_assert.svh
// assertion macros shared by the checker of the dv accumulator
// depends on nothing; included by the files that assert
`ifndef GQA_ATTENTION_DV_ACCUMULATE_CORE_ASSERT_SVH
`define GQA_ATTENTION_DV_ACCUMULATE_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define GQA_DV_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define GQA_DV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/gqa_dv_pkg.sv
// shared widths, limits and types of the dv accumulator
// depends on nothing; imported by the issue stage and the top level
package gqa_dv_pkg;

   // request and response payload widths
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 32;
   localparam int ACC_W       = 32;
   localparam int TERM_W      = 17;

   // accumulator limits
   localparam logic [ACC_W-1:0] ACC_MAX = 32'h7fff_ffff;
   localparam logic [ACC_W-1:0] ACC_MIN = 32'h8000_0000;

   // what the issue stage hands to the update stage besides the address
   typedef struct packed {
      logic                     in_range;
      logic signed [TERM_W-1:0] term;
   } issue_type;

endpackage

FILE: hw/rtl/gqa_dv_ram.sv
// generic single-port-write, single-port-read ram with registered read
// depends on nothing
module gqa_dv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port; a read of the entry written at
   // the same edge returns the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/gqa_dv_issue.sv
// issue stage: range check, store address and scaled gradient term
// depends on gqa_dv_pkg
module gqa_dv_issue #(
   parameter int QUERY_HEADS = 8,
   parameter int GROUP_SIZE  = 4,
   parameter int NUM_BLOCKS  = 4,
   parameter int BLOCK_LEN   = 16,
   parameter int HEAD_DIM    = 32,
   parameter int ADDR_W      = 12
) (
   input  logic [2:0]             query_head,
   input  logic [1:0]             block_index,
   input  logic [3:0]             position,
   input  logic [4:0]             value_dim,
   input  logic [15:0]            attn_weight,
   input  logic signed [15:0]     grad_out,
   output logic [ADDR_W-1:0]      addr,
   output gqa_dv_pkg::issue_type  info
);

   import gqa_dv_pkg::*;

   logic [2:0]         kv_head;
   logic [31:0]        addr_wide;
   logic signed [32:0] product;

   // query head to kv head, a small table over the eight head codes
   always_comb begin
      kv_head = '0;
      for (int i = 0; i < 8; i++) begin
         if (query_head == 3'(i)) begin
            kv_head = 3'(i / GROUP_SIZE);
         end
      end
   end

   // flat entry address
   assign addr_wide = 32'(((int'(kv_head) * NUM_BLOCKS + int'(block_index)) * BLOCK_LEN
                          + int'(position)) * HEAD_DIM + int'(value_dim));
   assign addr = addr_wide[ADDR_W-1:0];

   // all indices inside the configured shape
   assign info.in_range = (int'(query_head) < QUERY_HEADS) &&
                          (int'(block_index) < NUM_BLOCKS) &&
                          (int'(position) < BLOCK_LEN) &&
                          (int'(value_dim) < HEAD_DIM);

   // q0.16 times q3.12, floor shift by 16 back to q3.12
   assign product   = $signed({1'b0, attn_weight}) * grad_out;
   assign info.term = product[32:16];

endmodule

FILE: hw/rtl/gqa_attention_dv_accumulate_core.sv
// Grouped-query attention dV accumulator: read, add and write back one store entry per request.
// Stages: ram read into the update stage, then add and write back into the output register.
// Throughput: one request per cycle while responses are taken; the write of one request is
// forwarded to the next one on the same entry, so back-to-back updates of one entry need
// no bubble. Reset: clears control state, then a clearing pass writes zero to every store
// entry, one per cycle (STORE_DEPTH entries, 4096 at the defaults) with req_tready low.
module gqa_attention_dv_accumulate_core #(
   parameter int QUERY_HEADS = 8,
   parameter int GROUP_SIZE  = 4,
   parameter int NUM_BLOCKS  = 4,
   parameter int BLOCK_LEN   = 16,
   parameter int HEAD_DIM    = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: query_head[2:0], block_index[4:3], position[8:5], value_dim[13:9],
   // attn_weight[29:14], grad_out[45:30], zero pad[47:46]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gqa_dv_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // response: acc_value[31:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gqa_dv_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // response flag: saturated[0]
   output logic                                rsp_tuser
);

   import gqa_dv_pkg::*;

   localparam int KV_HEADS    = (QUERY_HEADS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int STORE_DEPTH = KV_HEADS * NUM_BLOCKS * BLOCK_LEN * HEAD_DIM;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

   // request fields
   logic [2:0]         req_query_head;
   logic [1:0]         req_block_index;
   logic [3:0]         req_position;
   logic [4:0]         req_value_dim;
   logic [15:0]        req_attn_weight;
   logic signed [15:0] req_grad_out;

   logic [ADDR_W-1:0] issue_addr;
   issue_type         issue_info;

   // control state
   logic clear_busy_ff, clear_busy_in;
   logic [ADDR_W-1:0] clear_cnt_ff, clear_cnt_in;
   logic s1_valid_ff, s1_valid_in;
   logic fwd_valid_ff, fwd_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   issue_type         s1_info_ff, s1_info_in;
   logic [ADDR_W-1:0] fwd_addr_ff, fwd_addr_in;
   logic [ACC_W-1:0]  fwd_data_ff, fwd_data_in;
   logic [ACC_W-1:0]  rsp_data_ff, rsp_data_in;
   logic              rsp_sat_ff, rsp_sat_in;

   // datapath
   logic              req_accept;
   logic              s1_fire;
   logic [ACC_W-1:0]  ram_rd_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [ACC_W-1:0]  ram_wr_data;
   logic [ACC_W-1:0]  old_value;
   logic [ACC_W:0]    sum_wide;
   logic              sum_sat;
   logic [ACC_W-1:0]  sum_clamped;

   // unpack the request
   assign req_query_head  = req_tdata[2:0];
   assign req_block_index = req_tdata[4:3];
   assign req_position    = req_tdata[8:5];
   assign req_value_dim   = req_tdata[13:9];
   assign req_attn_weight = req_tdata[29:14];
   assign req_grad_out    = $signed(req_tdata[45:30]);

   gqa_dv_issue #(
      .QUERY_HEADS (QUERY_HEADS),
      .GROUP_SIZE  (GROUP_SIZE),
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_LEN   (BLOCK_LEN),
      .HEAD_DIM    (HEAD_DIM),
      .ADDR_W      (ADDR_W)
   ) u_issue (
      .query_head  (req_query_head),
      .block_index (req_block_index),
      .position    (req_position),
      .value_dim   (req_value_dim),
      .attn_weight (req_attn_weight),
      .grad_out    (req_grad_out),
      .addr        (issue_addr),
      .info        (issue_info)
   );

   gqa_dv_ram #(
      .WIDTH (ACC_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // handshake
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clear_busy_ff && (!s1_valid_ff || s1_fire);
   assign req_accept = req_tvalid && req_tready;

   // read the new entry on acceptance, otherwise keep reading the waiting one
   assign ram_rd_addr = req_accept ? issue_addr : s1_addr_ff;

   // last write forwarded over the ram read of the same edge
   assign old_value = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : ram_rd_data;

   // exact sum and clamp to the 32-bit range
   assign sum_wide = {old_value[ACC_W-1], old_value} +
                     {{(ACC_W + 1 - TERM_W){s1_info_ff.term[TERM_W-1]}}, s1_info_ff.term};
   assign sum_sat  = sum_wide[ACC_W] ^ sum_wide[ACC_W-1];
   assign sum_clamped = sum_sat ? (sum_wide[ACC_W] ? ACC_MIN : ACC_MAX) : sum_wide[ACC_W-1:0];

   // store write: clearing pass, then updates of in-range requests
   always_comb begin
      if (clear_busy_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_fire && s1_info_ff.in_range;
         ram_wr_addr = s1_addr_ff;
         ram_wr_data = sum_clamped;
      end
   end

   // next state
   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_cnt_in  = clear_cnt_ff;
      s1_valid_in   = s1_valid_ff;
      s1_addr_in    = s1_addr_ff;
      s1_info_in    = s1_info_ff;
      fwd_valid_in  = fwd_valid_ff;
      fwd_addr_in   = fwd_addr_ff;
      fwd_data_in   = fwd_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_sat_in    = rsp_sat_ff;

      // clearing pass
      if (clear_busy_ff) begin
         clear_cnt_in = clear_cnt_ff + ADDR_W'(1);
         if (clear_cnt_ff == LAST_ADDR) begin
            clear_busy_in = 1'b0;
         end
      end

      // forwarding register follows every update write
      if (clear_busy_ff) begin
         fwd_valid_in = 1'b0;
      end else if (ram_wr_en) begin
         fwd_valid_in = 1'b1;
         fwd_addr_in  = s1_addr_ff;
         fwd_data_in  = sum_clamped;
      end

      // output register
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = s1_info_ff.in_range ? sum_clamped : '0;
         rsp_sat_in   = s1_info_ff.in_range && sum_sat;
      end

      // update stage
      if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_addr_in  = issue_addr;
         s1_info_in  = issue_info;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_cnt_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_cnt_ff  <= clear_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_addr_ff  <= s1_addr_in;
      s1_info_ff  <= s1_info_in;
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

endmodule

FILE: hw/rtl/gqa_dv_checker.sv
// port-level checker of the dv accumulator, bound to the top level
// depends on gqa_attention_dv_accumulate_core_assert.svh
`include "gqa_attention_dv_accumulate_core_assert.svh"

module gqa_dv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic [1:0] outstanding_ff, outstanding_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;

   // requests accepted whose response is not yet taken
   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_take && !rsp_take) begin
         outstanding_in = outstanding_ff + 2'd1;
      end else if (!req_take && rsp_take) begin
         outstanding_in = outstanding_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // store clearing keeps requests out right after reset
   `GQA_DV_ASSERT_NOW(a_clear_after_reset, clock, reset, $past(reset), !req_tready, "request taken during clearing pass")

   // a response only stands for an accepted request
   `GQA_DV_ASSERT_NOW(a_rsp_has_request, clock, reset, rsp_tvalid, outstanding_ff != 2'd0, "response without request")

   // at most the update stage and the output register hold requests
   `GQA_DV_ASSERT_NOW(a_outstanding_bound, clock, reset, 1'b1, outstanding_ff != 2'd3, "more than two requests in flight")

   // a saturated result sits at a limit
   `GQA_DV_ASSERT_NOW(a_sat_at_limit, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == 32'h7fff_ffff || rsp_tdata == 32'h8000_0000, "saturated result off the limits")

   // stalled response holds
   `GQA_DV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")

endmodule

bind gqa_attention_dv_accumulate_core gqa_dv_checker u_checker (.*);
